>>> design/obc_pkg.sv
package obc_pkg;

    localparam int WORD_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int SIZE_W   = 31;
    localparam int PROD_W   = 2 * WORD_W;
    localparam int WIDE_W   = PROD_W + 2;
    localparam int SQ_W     = 2 * WORD_W;
    localparam int ROOT_W   = WORD_W;
    localparam int NUM_ROOT = 3;
    localparam int QUO_W    = FRAC_W + 2;
    localparam int DIV_N    = FRAC_W + 1;
    localparam int REM_W    = WORD_W + FRAC_W + 1;
    localparam int PR2_W    = WORD_W + QUO_W;

    localparam int ROOT_SX = 0;
    localparam int ROOT_SY = 1;
    localparam int ROOT_H  = 2;

    localparam logic signed [WORD_W-1:0] W_MAX   = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] W_MIN   = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [ROOT_W-1:0]        LEN_MAX = {1'b0, {(ROOT_W-1){1'b1}}};
    localparam logic signed [QUO_W-1:0]  Q_ONE   = {2'b01, {FRAC_W{1'b0}}};

    typedef struct packed {
        logic signed [WORD_W-1:0] m00;
        logic signed [WORD_W-1:0] m01;
        logic signed [WORD_W-1:0] m10;
        logic signed [WORD_W-1:0] m11;
        logic signed [WORD_W-1:0] ox;
        logic signed [WORD_W-1:0] oy;
        logic signed [WORD_W-1:0] px;
        logic signed [WORD_W-1:0] py;
        logic [SIZE_W-1:0]        w;
        logic [SIZE_W-1:0]        h;
    } t_item;

    typedef struct packed {
        logic signed [WORD_W-1:0] plx;
        logic signed [WORD_W-1:0] ply;
        logic signed [WORD_W-1:0] pwx;
        logic signed [WORD_W-1:0] pwy;
        logic signed [WORD_W-1:0] m00;
        logic signed [WORD_W-1:0] m10;
        logic [SIZE_W-1:0]        w;
        logic [SIZE_W-1:0]        h;
    } t_side;

    typedef struct packed {
        logic signed [WORD_W-1:0] plx;
        logic signed [WORD_W-1:0] ply;
        logic signed [WORD_W-1:0] pwx;
        logic signed [WORD_W-1:0] pwy;
        logic [SIZE_W-1:0]        w;
        logic [SIZE_W-1:0]        h;
        logic signed [WORD_W-1:0] scx;
        logic signed [WORD_W-1:0] scy;
        logic                     zero;
        logic                     neg_c;
        logic                     neg_s;
    } t_dside;

    typedef struct packed {
        logic signed [WORD_W-1:0] plx;
        logic signed [WORD_W-1:0] ply;
        logic signed [WORD_W-1:0] pwx;
        logic signed [WORD_W-1:0] pwy;
        logic [SIZE_W-1:0]        w;
        logic [SIZE_W-1:0]        h;
        logic signed [WORD_W-1:0] scx;
        logic signed [WORD_W-1:0] scy;
        logic signed [QUO_W-1:0]  cs;
        logic signed [QUO_W-1:0]  sn;
    } t_geom;

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > WIDE_W'(W_MAX)) begin
            r = W_MAX;
        end else if (v < WIDE_W'(W_MIN)) begin
            r = W_MIN;
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] mag(input logic signed [WORD_W-1:0] v);
        logic [WORD_W-1:0] r;
        if (v[WORD_W-1]) begin
            r = $unsigned(-v);
        end else begin
            r = $unsigned(v);
        end
        return r;
    endfunction

endpackage

>>> design/oriented_box_corners.sv
// channel   direction  item
// s_axis    in         one entity: matrix, offset, pivot, size
// m_axis    out        four world-space corners
//
// One item per cycle while the output is not held; the stages run front, square root,
// division and corners, the root and quotient pipelines giving one bit per stage.
// Reset clears the valid bits only; the data path is not reset.
// Whole pipeline advances together: a held output freezes every stage; the
// input is ready whenever the output is empty or being taken.
module oriented_box_corners import obc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // matrix_00, matrix_01, matrix_10, matrix_11, offset_x, offset_y,
    // pivot_x, pivot_y, size_w, size_h, 2 bits zero
    input  logic [319:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // corner0_x, corner0_y, corner1_x, corner1_y,
    // corner2_x, corner2_y, corner3_x, corner3_y
    output logic [255:0] o_m_axis_tdata
);

    logic  w_en;
    t_item w_item;
    logic  w_f_valid, w_r_valid, w_d_valid;
    t_side w_f_side, w_r_side;
    t_geom w_geom;
    logic [SQ_W-1:0]   w_rad [NUM_ROOT];
    logic [ROOT_W-1:0] w_root [NUM_ROOT];
    logic signed [WORD_W-1:0] w_cx [4];
    logic signed [WORD_W-1:0] w_cy [4];

    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    assign w_item.m00 = i_s_axis_tdata[0*WORD_W +: WORD_W];
    assign w_item.m01 = i_s_axis_tdata[1*WORD_W +: WORD_W];
    assign w_item.m10 = i_s_axis_tdata[2*WORD_W +: WORD_W];
    assign w_item.m11 = i_s_axis_tdata[3*WORD_W +: WORD_W];
    assign w_item.ox  = i_s_axis_tdata[4*WORD_W +: WORD_W];
    assign w_item.oy  = i_s_axis_tdata[5*WORD_W +: WORD_W];
    assign w_item.px  = i_s_axis_tdata[6*WORD_W +: WORD_W];
    assign w_item.py  = i_s_axis_tdata[7*WORD_W +: WORD_W];
    assign w_item.w   = i_s_axis_tdata[8*WORD_W +: SIZE_W];
    assign w_item.h   = i_s_axis_tdata[8*WORD_W+SIZE_W +: SIZE_W];

    obc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_item  (w_item),
        .o_valid (w_f_valid),
        .o_side  (w_f_side),
        .o_rad   (w_rad)
    );

    obc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_side  (w_f_side),
        .i_rad   (w_rad),
        .o_valid (w_r_valid),
        .o_side  (w_r_side),
        .o_root  (w_root)
    );

    obc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_r_valid),
        .i_side  (w_r_side),
        .i_root  (w_root),
        .o_valid (w_d_valid),
        .o_geom  (w_geom)
    );

    obc_corner u_corner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d_valid),
        .i_geom  (w_geom),
        .o_valid (o_m_axis_tvalid),
        .o_cx    (w_cx),
        .o_cy    (w_cy)
    );

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            o_m_axis_tdata[2*k*WORD_W +: WORD_W]     = w_cx[k];
            o_m_axis_tdata[(2*k+1)*WORD_W +: WORD_W] = w_cy[k];
        end
    end

`ifndef SYNTH
    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("input taken while output held");
`endif

`ifndef SYNTH
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid straight after reset");
`endif

endmodule

>>> design/obc_front.sv
module obc_front import obc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_valid,
    output t_side       o_side,
    output logic [SQ_W-1:0] o_rad [NUM_ROOT]
);

    logic [3:0] r_valid;
    t_item      r1_item, r2_item, r3_item;

    logic signed [PROD_W-1:0] n1_pxw, n1_pyh, r1_pxw, r1_pyh;
    logic [WORD_W-1:0]        n1_mag [4];
    logic [PROD_W-1:0]        n1_sq [4];
    logic [PROD_W-1:0]        r1_sq [4];

    logic signed [WORD_W-1:0] n2_plx, n2_ply, r2_plx, r2_ply, r3_plx, r3_ply;
    logic [SQ_W-1:0]          n2_rad [NUM_ROOT];
    logic [SQ_W-1:0]          r2_rad [NUM_ROOT];
    logic [SQ_W-1:0]          r3_rad [NUM_ROOT];
    logic [SQ_W-1:0]          r4_rad [NUM_ROOT];

    logic signed [PROD_W-1:0] n3_p [4];
    logic signed [PROD_W-1:0] r3_p [4];

    t_side n4_side, r4_side;

    // stage 1: pivot products and squared magnitudes
    always_comb begin
        n1_pxw    = i_item.px * $signed({1'b0, i_item.w});
        n1_pyh    = i_item.py * $signed({1'b0, i_item.h});
        n1_mag[0] = mag(i_item.m00);
        n1_mag[1] = mag(i_item.m01);
        n1_mag[2] = mag(i_item.m10);
        n1_mag[3] = mag(i_item.m11);
        for (int i = 0; i < 4; i++) begin
            n1_sq[i] = n1_mag[i] * n1_mag[i];
        end
    end

    // stage 2: local pivot, squared lengths
    always_comb begin
        n2_plx = sat_word(WIDE_W'(r1_pxw >>> FRAC_W));
        n2_ply = sat_word(WIDE_W'(r1_pyh >>> FRAC_W));
        n2_rad[ROOT_SX] = r1_sq[0] + r1_sq[1];
        n2_rad[ROOT_SY] = r1_sq[2] + r1_sq[3];
        n2_rad[ROOT_H]  = r1_sq[0] + r1_sq[2];
    end

    // stage 3: pivot through the matrix
    always_comb begin
        n3_p[0] = r2_item.m00 * r2_plx;
        n3_p[1] = r2_item.m10 * r2_ply;
        n3_p[2] = r2_item.m01 * r2_plx;
        n3_p[3] = r2_item.m11 * r2_ply;
    end

    // stage 4: world pivot
    always_comb begin
        n4_side.plx = r3_plx;
        n4_side.ply = r3_ply;
        n4_side.pwx = sat_word(WIDE_W'(r3_p[0] >>> FRAC_W) + WIDE_W'(r3_p[1] >>> FRAC_W)
                               + WIDE_W'(r3_item.ox));
        n4_side.pwy = sat_word(WIDE_W'(r3_p[2] >>> FRAC_W) + WIDE_W'(r3_p[3] >>> FRAC_W)
                               + WIDE_W'(r3_item.oy));
        n4_side.m00 = r3_item.m00;
        n4_side.m10 = r3_item.m10;
        n4_side.w   = r3_item.w;
        n4_side.h   = r3_item.h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_item <= i_item;
            r1_pxw  <= n1_pxw;
            r1_pyh  <= n1_pyh;
            r1_sq   <= n1_sq;
            r2_item <= r1_item;
            r2_plx  <= n2_plx;
            r2_ply  <= n2_ply;
            r2_rad  <= n2_rad;
            r3_item <= r2_item;
            r3_plx  <= r2_plx;
            r3_ply  <= r2_ply;
            r3_rad  <= r2_rad;
            r3_p    <= n3_p;
            r4_rad  <= r3_rad;
            r4_side <= n4_side;
        end
    end

    assign o_valid = r_valid[3];
    assign o_side  = r4_side;
    assign o_rad   = r4_rad;

endmodule

>>> design/obc_isqrt.sv
module obc_isqrt import obc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_side       i_side,
    input  logic [SQ_W-1:0] i_rad [NUM_ROOT],
    output logic        o_valid,
    output t_side       o_side,
    output logic [ROOT_W-1:0] o_root [NUM_ROOT]
);

    // one result bit per stage, three roots side by side
    logic [ROOT_W-1:0] r_valid;
    t_side             r_side [ROOT_W];
    logic [SQ_W-1:0]   r_rem [ROOT_W][NUM_ROOT];
    logic [SQ_W-1:0]   r_res [ROOT_W][NUM_ROOT];
    logic [SQ_W-1:0]   n_rem [ROOT_W][NUM_ROOT];
    logic [SQ_W-1:0]   n_res [ROOT_W][NUM_ROOT];

    always_comb begin
        logic [SQ_W-1:0] rem_in;
        logic [SQ_W-1:0] res_in;
        logic [SQ_W-1:0] bitv;
        logic [SQ_W:0]   trial;
        for (int k = 0; k < ROOT_W; k++) begin
            for (int l = 0; l < NUM_ROOT; l++) begin
                if (k == 0) begin
                    rem_in = i_rad[l];
                    res_in = '0;
                end else begin
                    rem_in = r_rem[k-1][l];
                    res_in = r_res[k-1][l];
                end
                bitv  = SQ_W'(1) << (SQ_W - 2 - 2 * k);
                trial = {1'b0, res_in} + {1'b0, bitv};
                if ({1'b0, rem_in} >= trial) begin
                    n_rem[k][l] = rem_in - trial[SQ_W-1:0];
                    n_res[k][l] = (res_in >> 1) + bitv;
                end else begin
                    n_rem[k][l] = rem_in;
                    n_res[k][l] = res_in >> 1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[ROOT_W-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem     <= n_rem;
            r_res     <= n_res;
            r_side[0] <= i_side;
            for (int k = 1; k < ROOT_W; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_valid[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

    always_comb begin
        for (int l = 0; l < NUM_ROOT; l++) begin
            o_root[l] = r_res[ROOT_W-1][l][ROOT_W-1:0];
        end
    end

endmodule

>>> design/obc_div.sv
module obc_div import obc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_side       i_side,
    input  logic [ROOT_W-1:0] i_root [NUM_ROOT],
    output logic        o_valid,
    output t_geom       o_geom
);

    // restoring division, one quotient bit per stage; lane 0 cosine, lane 1 sine
    logic [DIV_N-1:0]  r_valid;
    t_dside            r_side [DIV_N];
    logic [ROOT_W-1:0] r_hr [DIV_N];
    logic [REM_W-1:0]  r_rem [DIV_N][2];
    logic [DIV_N-1:0]  r_q [DIV_N][2];
    logic [REM_W-1:0]  n_rem [DIV_N][2];
    logic [DIV_N-1:0]  n_q [DIV_N][2];
    t_dside            n_side;
    logic [REM_W-1:0]  n_num [2];

    always_comb begin
        n_side.plx   = i_side.plx;
        n_side.ply   = i_side.ply;
        n_side.pwx   = i_side.pwx;
        n_side.pwy   = i_side.pwy;
        n_side.w     = i_side.w;
        n_side.h     = i_side.h;
        n_side.scx   = (i_root[ROOT_SX] > LEN_MAX) ? W_MAX : $signed(i_root[ROOT_SX]);
        n_side.scy   = (i_root[ROOT_SY] > LEN_MAX) ? W_MAX : $signed(i_root[ROOT_SY]);
        n_side.zero  = (i_root[ROOT_H] == '0);
        n_side.neg_c = i_side.m00[WORD_W-1];
        n_side.neg_s = i_side.m10[WORD_W-1];
        n_num[0]     = {1'b0, mag(i_side.m00), {FRAC_W{1'b0}}};
        n_num[1]     = {1'b0, mag(i_side.m10), {FRAC_W{1'b0}}};
    end

    always_comb begin
        logic [REM_W-1:0]  rem_in;
        logic [DIV_N-1:0]  q_in;
        logic [ROOT_W-1:0] hr_in;
        logic [REM_W-1:0]  dsh;
        for (int k = 0; k < DIV_N; k++) begin
            for (int l = 0; l < 2; l++) begin
                if (k == 0) begin
                    rem_in = n_num[l];
                    q_in   = '0;
                    hr_in  = i_root[ROOT_H];
                end else begin
                    rem_in = r_rem[k-1][l];
                    q_in   = r_q[k-1][l];
                    hr_in  = r_hr[k-1];
                end
                dsh = REM_W'(hr_in) << (DIV_N - 1 - k);
                if (rem_in >= dsh) begin
                    n_rem[k][l] = rem_in - dsh;
                    n_q[k][l]   = {q_in[DIV_N-2:0], 1'b1};
                end else begin
                    n_rem[k][l] = rem_in;
                    n_q[k][l]   = {q_in[DIV_N-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[DIV_N-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem     <= n_rem;
            r_q       <= n_q;
            r_side[0] <= n_side;
            r_hr[0]   <= i_root[ROOT_H];
            for (int k = 1; k < DIV_N; k++) begin
                r_side[k] <= r_side[k-1];
                r_hr[k]   <= r_hr[k-1];
            end
        end
    end

    logic signed [QUO_W-1:0] w_qc, w_qs;
    t_dside                  w_last;

    assign w_last = r_side[DIV_N-1];
    assign w_qc   = $signed({1'b0, r_q[DIV_N-1][0]});
    assign w_qs   = $signed({1'b0, r_q[DIV_N-1][1]});

    always_comb begin
        o_geom.plx = w_last.plx;
        o_geom.ply = w_last.ply;
        o_geom.pwx = w_last.pwx;
        o_geom.pwy = w_last.pwy;
        o_geom.w   = w_last.w;
        o_geom.h   = w_last.h;
        o_geom.scx = w_last.scx;
        o_geom.scy = w_last.scy;
        if (w_last.zero) begin
            o_geom.cs = Q_ONE;
            o_geom.sn = '0;
        end else begin
            o_geom.cs = w_last.neg_c ? -w_qc : w_qc;
            o_geom.sn = w_last.neg_s ? -w_qs : w_qs;
        end
    end

    assign o_valid = r_valid[DIV_N-1];

`ifndef SYNTH
    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_geom.cs <= Q_ONE) && (o_geom.cs >= -Q_ONE)
                 && (o_geom.sn <= Q_ONE) && (o_geom.sn >= -Q_ONE))
        else $error("rotation term out of unit range");
`endif

endmodule

>>> design/obc_corner.sv
module obc_corner import obc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_geom       i_geom,
    output logic        o_valid,
    output logic signed [WORD_W-1:0] o_cx [4],
    output logic signed [WORD_W-1:0] o_cy [4]
);

    logic [4:0] r_valid;

    // index 0: left/top edge, index 1: right/bottom edge
    logic signed [WORD_W-1:0] n1_lx [2];
    logic signed [WORD_W-1:0] n1_ly [2];
    logic signed [WORD_W-1:0] r1_lx [2];
    logic signed [WORD_W-1:0] r1_ly [2];
    t_geom                    r1_g, r2_g, r3_g, r4_g;

    logic signed [PROD_W-1:0] n2_px [2];
    logic signed [PROD_W-1:0] n2_py [2];
    logic signed [PROD_W-1:0] r2_px [2];
    logic signed [PROD_W-1:0] r2_py [2];

    logic signed [WORD_W-1:0] n3_sx [2];
    logic signed [WORD_W-1:0] n3_sy [2];
    logic signed [WORD_W-1:0] r3_sx [2];
    logic signed [WORD_W-1:0] r3_sy [2];

    logic signed [PR2_W-1:0]  n4_xc [2];
    logic signed [PR2_W-1:0]  n4_xs [2];
    logic signed [PR2_W-1:0]  n4_yc [2];
    logic signed [PR2_W-1:0]  n4_ys [2];
    logic signed [PR2_W-1:0]  r4_xc [2];
    logic signed [PR2_W-1:0]  r4_xs [2];
    logic signed [PR2_W-1:0]  r4_yc [2];
    logic signed [PR2_W-1:0]  r4_ys [2];

    logic signed [WORD_W-1:0] n5_cx [4];
    logic signed [WORD_W-1:0] n5_cy [4];
    logic signed [WORD_W-1:0] r5_cx [4];
    logic signed [WORD_W-1:0] r5_cy [4];

    always_comb begin
        n1_lx[0] = sat_word(-WIDE_W'(i_geom.plx));
        n1_lx[1] = sat_word(WIDE_W'($signed({1'b0, i_geom.w})) - WIDE_W'(i_geom.plx));
        n1_ly[0] = sat_word(-WIDE_W'(i_geom.ply));
        n1_ly[1] = sat_word(WIDE_W'($signed({1'b0, i_geom.h})) - WIDE_W'(i_geom.ply));
    end

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            n2_px[a] = r1_lx[a] * r1_g.scx;
            n2_py[a] = r1_ly[a] * r1_g.scy;
            n3_sx[a] = sat_word(WIDE_W'(r2_px[a] >>> FRAC_W));
            n3_sy[a] = sat_word(WIDE_W'(r2_py[a] >>> FRAC_W));
            n4_xc[a] = r3_sx[a] * r3_g.cs;
            n4_xs[a] = r3_sx[a] * r3_g.sn;
            n4_yc[a] = r3_sy[a] * r3_g.cs;
            n4_ys[a] = r3_sy[a] * r3_g.sn;
        end
    end

    // corners run clockwise from top-left
    always_comb begin
        logic ix;
        logic iy;
        for (int k = 0; k < 4; k++) begin
            ix = (k == 1 || k == 2);
            iy = (k >= 2);
            n5_cx[k] = sat_word(WIDE_W'(r4_g.pwx) + WIDE_W'(r4_xc[ix] >>> FRAC_W)
                                - WIDE_W'(r4_ys[iy] >>> FRAC_W));
            n5_cy[k] = sat_word(WIDE_W'(r4_g.pwy) + WIDE_W'(r4_xs[ix] >>> FRAC_W)
                                + WIDE_W'(r4_yc[iy] >>> FRAC_W));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_lx <= n1_lx;
            r1_ly <= n1_ly;
            r1_g  <= i_geom;
            r2_px <= n2_px;
            r2_py <= n2_py;
            r2_g  <= r1_g;
            r3_sx <= n3_sx;
            r3_sy <= n3_sy;
            r3_g  <= r2_g;
            r4_xc <= n4_xc;
            r4_xs <= n4_xs;
            r4_yc <= n4_yc;
            r4_ys <= n4_ys;
            r4_g  <= r3_g;
            r5_cx <= n5_cx;
            r5_cy <= n5_cy;
        end
    end

    assign o_valid = r_valid[4];
    assign o_cx    = r5_cx;
    assign o_cy    = r5_cy;

endmodule

>>> dv/tb.sv
module tb;
    import obc_pkg::*;

    localparam int LATENCY   = 58;
    localparam int N_RANDOM  = 730;
    localparam int WD_LIMIT  = 4000;

    typedef struct {
        logic signed [31:0] m00, m01, m10, m11, ox, oy, px, py;
        logic [30:0]        w, h;
    } t_entity;

    typedef struct {
        logic signed [31:0] x [4];
        logic signed [31:0] y [4];
    } t_corners;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [319:0] i_s_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [255:0] o_m_axis_tdata;

    oriented_box_corners u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    t_corners corners_due[$];
    t_entity  directed_rows[$];
    t_corners directed_known[$];
    bit       directed_has_known[$];
    int       errors;
    int       idle_cycles;
    bit       sending_done;
    bit       long_hold;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // floor of a Q16.16 product, wrapping at 64 bits
    function automatic longint qmul(input longint a, input longint b);
        return (a * b) >>> 16;
    endfunction

    function automatic longint root_floor(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint vec_len(input longint a, input longint b);
        logic [63:0] ma, mb;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        return root_floor(ma * ma + mb * mb);
    endfunction

    function automatic t_corners box_corners(input t_entity e);
        t_corners r;
        longint m00, m01, m10, m11, w, h, plx, ply, pwx, pwy, scx, scy, hl, cs, sn;
        longint lx [4];
        longint ly [4];
        longint sx, sy;
        m00 = e.m00; m01 = e.m01; m10 = e.m10; m11 = e.m11;
        w = longint'(e.w); h = longint'(e.h);
        plx = sat32(qmul(e.px, w));
        ply = sat32(qmul(e.py, h));
        pwx = sat32(qmul(m00, plx) + qmul(m10, ply) + e.ox);
        pwy = sat32(qmul(m01, plx) + qmul(m11, ply) + e.oy);
        scx = sat32(vec_len(m00, m01));
        scy = sat32(vec_len(m10, m11));
        hl  = vec_len(m00, m10);
        if (hl == 0) begin
            cs = 64'sd65536;
            sn = 0;
        end else begin
            cs = (m00 * 65536) / hl;
            sn = (m10 * 65536) / hl;
        end
        lx[0] = -plx;    ly[0] = -ply;
        lx[1] = w - plx; ly[1] = -ply;
        lx[2] = w - plx; ly[2] = h - ply;
        lx[3] = -plx;    ly[3] = h - ply;
        for (int k = 0; k < 4; k++) begin
            sx = sat32(qmul(sat32(lx[k]), scx));
            sy = sat32(qmul(sat32(ly[k]), scy));
            r.x[k] = 32'(sat32(pwx + qmul(sx, cs) - qmul(sy, sn)));
            r.y[k] = 32'(sat32(pwy + qmul(sx, sn) + qmul(sy, cs)));
        end
        return r;
    endfunction

    function automatic logic [319:0] pack_entity(input t_entity e);
        return {2'b00, e.h, e.w, e.py, e.px, e.oy, e.ox, e.m11, e.m10, e.m01, e.m00};
    endfunction

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'($urandom_range(0, 262144)) - 32'sd131072;
            3: return 32'($urandom_range(0, 8388608)) - 32'sd4194304;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_entity rand_entity();
        t_entity e;
        e.m00 = rand_word(); e.m01 = rand_word();
        e.m10 = rand_word(); e.m11 = rand_word();
        e.ox = rand_word(); e.oy = rand_word();
        e.px = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 65536) : rand_word();
        e.py = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 65536) : rand_word();
        e.w = ($urandom_range(0, 2) == 0) ? 31'($urandom) : 31'($urandom_range(0, 4194304));
        e.h = ($urandom_range(0, 2) == 0) ? 31'($urandom) : 31'($urandom_range(0, 4194304));
        if ($urandom_range(0, 15) == 0) begin
            e.m00 = 0;
            e.m10 = 0;
        end
        return e;
    endfunction

    function automatic t_entity mk(input logic signed [31:0] m00, m01, m10, m11, ox, oy,
                                   px, py, input logic [30:0] w, h);
        t_entity e;
        e.m00 = m00; e.m01 = m01; e.m10 = m10; e.m11 = m11;
        e.ox = ox; e.oy = oy; e.px = px; e.py = py; e.w = w; e.h = h;
        return e;
    endfunction

    task automatic add_row(input t_entity e, input bit known, input t_corners c);
        directed_rows.push_back(e);
        directed_has_known.push_back(known);
        directed_known.push_back(c);
    endtask

    task automatic build_table();
        t_corners zero_box;
        t_corners none;
        logic signed [31:0] one;
        one = 32'sh0001_0000;
        for (int k = 0; k < 4; k++) begin
            zero_box.x[k] = 0;
            zero_box.y[k] = 0;
            none.x[k] = 0;
            none.y[k] = 0;
        end
        // all zero: degenerate rotation, every corner at the origin
        add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_box);
        // identity, unit box, no pivot
        zero_box.x[1] = one; zero_box.x[2] = one;
        zero_box.y[2] = one; zero_box.y[3] = one;
        add_row(mk(one, 0, 0, one, 0, 0, 0, 0, 31'h1_0000, 31'h1_0000), 1, zero_box);
        // degenerate rotation with a nonzero column 1 row 1
        add_row(mk(0, one, 0, one, one, one, 32'sh8000, 32'sh8000, 31'h1_0000,
                   31'h1_0000), 0, none);
        add_row(mk(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX,
                   31'h7fff_ffff, 31'h7fff_ffff), 0, none);
        add_row(mk(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN,
                   31'h7fff_ffff, 31'h7fff_ffff), 0, none);
        add_row(mk(W_MIN, W_MAX, W_MAX, W_MIN, W_MAX, W_MIN, W_MIN, W_MAX, 0,
                   31'h7fff_ffff), 0, none);
        add_row(mk(-one, 0, 0, -one, W_MIN, W_MAX, one, one, 31'h7fff_ffff, 0), 0, none);
        add_row(mk(0, one, -one, 0, 0, 0, 32'sh8000, 32'sh8000, 31'h2_0000,
                   31'h1_0000), 0, none);
        add_row(mk(32'sh0000b505, 32'sh0000b505, 32'shffff4afb, 32'sh0000b505,
                   32'sh00640000, -32'sh00640000, 32'sh8000, 32'sh4000,
                   31'h0010_0000, 31'h0008_0000), 0, none);
        add_row(mk(W_MIN, 0, 0, W_MIN, 0, 0, -one, -one, 31'h7fff_ffff,
                   31'h7fff_ffff), 0, none);
        add_row(mk(W_MAX, 0, W_MIN, 0, 0, 0, 0, 0, 31'h1_0000, 31'h1_0000), 0, none);
        add_row(mk(1, -1, -1, 1, 1, -1, 1, -1, 1, 1), 0, none);
        add_row(mk(32'sh5555_5555, 32'shaaaa_aaaa, 32'shaaaa_aaaa, 32'sh5555_5555,
                   32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa,
                   31'h5555_5555, 31'h2aaa_aaaa), 0, none);
        add_row(mk(32'shaaaa_aaaa, 32'sh5555_5555, 32'sh5555_5555, 32'shaaaa_aaaa,
                   32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555,
                   31'h2aaa_aaaa, 31'h5555_5555), 0, none);
    endtask

    // valid drops only across a gap, so back-to-back items never see two
    // assignments to it at one edge
    task automatic send_entity(input t_entity e);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 4) == 0) gap = 0;
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= pack_entity(e);
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // sender
    initial begin
        t_entity e;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        errors          = 0;
        sending_done    = 1'b0;
        build_table();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_rows[i]) begin
            if (directed_has_known[i]) corners_due.push_back(directed_known[i]);
            else corners_due.push_back(box_corners(directed_rows[i]));
            send_entity(directed_rows[i]);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            e = rand_entity();
            corners_due.push_back(box_corners(e));
            // a burst sent while the receiver holds off
            if (n == 100) long_hold <= 1'b1;
            send_entity(e);
        end
        i_s_axis_tvalid <= 1'b0;
        sending_done    <= 1'b1;
    end

    // receiver
    initial begin
        int gap;
        i_m_axis_tready = 1'b0;
        long_hold       = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                long_hold <= 1'b0;
            end else if (o_m_axis_tvalid && i_m_axis_tready) begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
                if (gap != 0) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // checker
    always @(posedge i_clk) begin
        t_corners want;
        logic signed [31:0] got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (corners_due.size() == 0) begin
                $display("%0t: unexpected item %h", $time, o_m_axis_tdata);
                errors++;
            end else begin
                want = corners_due.pop_front();
                for (int k = 0; k < 4; k++) begin
                    got = o_m_axis_tdata[64*k +: 32];
                    if (got !== want.x[k]) begin
                        $display("%0t: corner%0d_x expected %0d got %0d",
                                 $time, k, want.x[k], got);
                        errors++;
                    end
                    got = o_m_axis_tdata[64*k+32 +: 32];
                    if (got !== want.y[k]) begin
                        $display("%0t: corner%0d_y expected %0d got %0d",
                                 $time, k, want.y[k], got);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog and end of run
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WD_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
            if (sending_done && corners_due.size() == 0) begin
                repeat (2 * LATENCY) @(posedge i_clk);
                if (errors == 0) begin
                    $display("simulation ok");
                end else begin
                    $display("simulation failed");
                end
                $finish;
            end
        end
    end

endmodule

>>> oriented_box_corners.f
design/obc_pkg.sv
design/obc_front.sv
design/obc_isqrt.sv
design/obc_div.sv
design/obc_corner.sv
design/oriented_box_corners.sv
dv/tb.sv
